// ===== design/ppmfd_pkg.sv =====
// Shared types, codes and reset constants of the PPM frame decoder.
package ppmfd_pkg;

    // Widths of the item fields and of the decoder state
    localparam int TIME_W   = 16;
    localparam int US_W     = 15;
    localparam int CFG_W    = 15;
    localparam int CHAN_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 3;

    // Default number of channels in one frame
    localparam int CHANNELS_DEF = 8;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SYNC    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHANNEL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOST    = 2'd3;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_SYNC_MIN  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_SYNC_MAX  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_PULSE_MIN = 3'd2;
    localparam logic [INDEX_W-1:0] REG_PULSE_MAX = 3'd3;
    localparam logic [INDEX_W-1:0] REG_CENTER    = 3'd4;

    // Configuration reset values in microseconds
    localparam logic [CFG_W-1:0] SYNC_MIN_RST  = 15'd4000;
    localparam logic [CFG_W-1:0] SYNC_MAX_RST  = 15'd16000;
    localparam logic [CFG_W-1:0] PULSE_MIN_RST = 15'd800;
    localparam logic [CFG_W-1:0] PULSE_MAX_RST = 15'd2200;
    localparam logic [CFG_W-1:0] CENTER_RST    = 15'd1500;

    // Limits and center used by the decode logic
    typedef struct packed {
        logic [CFG_W-1:0] sync_min_us;
        logic [CFG_W-1:0] sync_max_us;
        logic [CFG_W-1:0] pulse_min_us;
        logic [CFG_W-1:0] pulse_max_us;
        logic [CFG_W-1:0] center_us;
    } t_cfg;

    // One decoded result item
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [CHAN_W-1:0]         channel;
        logic signed [VALUE_W-1:0] value;
        logic                      frame_done;
    } t_result;

endpackage

// ===== design/ppm_frame_decoder_core.sv =====
// Top level of the PPM frame decoder: handshakes, configuration and state registers.
//
// Decodes an RC PPM pulse train from 2 MHz capture timestamps. Every accepted
// capture item yields exactly one result item (ignored, sync found, channel
// value or sync lost). The block takes one item per cycle while the output is
// not stalled. An item sits in the input register, where a single subtract and a
// few compares decide its result. The result then moves to the output register
// and waits there until it is taken. The input stalls only when both registers
// hold an item and the output is stalled. Frame position and the previous
// timestamp update as each result is registered. Configuration writes are
// always ready and should be issued only while no item is in flight.
module ppm_frame_decoder_core #(
    parameter int CHANNELS = ppmfd_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // capture items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ppmfd_pkg::TIME_W-1:0]        i_capture_time,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ppmfd_pkg::STATUS_W-1:0]      o_status,
    output logic [ppmfd_pkg::CHAN_W-1:0]        o_channel,
    output logic signed [ppmfd_pkg::VALUE_W-1:0] o_value,
    output logic                                o_frame_done,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppmfd_pkg::INDEX_W-1:0]       i_cfg_index,
    input  logic [ppmfd_pkg::CFG_W-1:0]         i_cfg_data
);
    import ppmfd_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;
    t_result           r_res;
    logic [TIME_W-1:0] r_prev;
    logic [POS_W-1:0]  r_pos;

    t_result           w_res;
    logic [POS_W-1:0]  n_pos;
    logic              w_adv;
    logic              w_load;
    logic              w_accept;

    // Advance when the output register is empty or being drained
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_load      = w_adv && r_in_valid;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_min_us  <= SYNC_MIN_RST;
            r_cfg.sync_max_us  <= SYNC_MAX_RST;
            r_cfg.pulse_min_us <= PULSE_MIN_RST;
            r_cfg.pulse_max_us <= PULSE_MAX_RST;
            r_cfg.center_us    <= CENTER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SYNC_MIN:  r_cfg.sync_min_us  <= i_cfg_data;
                REG_SYNC_MAX:  r_cfg.sync_max_us  <= i_cfg_data;
                REG_PULSE_MIN: r_cfg.pulse_min_us <= i_cfg_data;
                REG_PULSE_MAX: r_cfg.pulse_max_us <= i_cfg_data;
                REG_CENTER:    r_cfg.center_us    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the incoming item; an empty input register fills even while the output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv || !r_in_valid) begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_time <= i_capture_time;
        end
    end

    // Decode the held item against the current frame state
    ppmfd_decode #(
        .CHANNELS (CHANNELS)
    ) u_decode (
        .i_time     (r_in_time),
        .i_prev     (r_prev),
        .i_pos      (r_pos),
        .i_cfg      (r_cfg),
        .o_res      (w_res),
        .o_pos_next (n_pos)
    );

    // Update frame state as the result is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_pos  <= '0;
        end else if (w_load) begin
            r_prev <= r_in_time;
            r_pos  <= n_pos;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_res.status;
    assign o_channel    = r_res.channel;
    assign o_value      = r_res.value;
    assign o_frame_done = r_res.frame_done;

    // Frame position never passes the last channel
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(CHANNELS))
        else $error("frame position beyond last channel");

    // Fields other than status are zero unless a channel value is reported
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_CHANNEL) |->
            (o_channel == '0 && o_value == '0 && !o_frame_done))
        else $error("result fields set without a channel value");

    // A sync result arms the decoder at the first channel
    a_sync_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res.status == ST_SYNC) |=> (r_pos == POS_W'(1)))
        else $error("sync found without arming");

    // Frame end and sync loss return the decoder to waiting for sync
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_res.frame_done || w_res.status == ST_LOST)) |=> (r_pos == '0))
        else $error("decoder still armed after frame end or sync loss");

    // The input side stalls only when a held item cannot move on
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked item");

endmodule

// ===== design/ppmfd_decode.sv =====
// Interval measurement and frame state decision for one capture item.
module ppmfd_decode #(
    parameter int CHANNELS = ppmfd_pkg::CHANNELS_DEF
) (
    input  logic [ppmfd_pkg::TIME_W-1:0] i_time,
    input  logic [ppmfd_pkg::TIME_W-1:0] i_prev,
    input  logic [ppmfd_pkg::POS_W-1:0]  i_pos,
    input  ppmfd_pkg::t_cfg              i_cfg,
    output ppmfd_pkg::t_result           o_res,
    output logic [ppmfd_pkg::POS_W-1:0]  o_pos_next
);
    import ppmfd_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(CHANNELS);

    logic [TIME_W-1:0]  w_diff;
    logic [US_W-1:0]    w_us;
    logic               w_armed;
    logic               w_in_pulse;
    logic               w_in_sync;
    logic [POS_W-1:0]   w_idx;

    // Measure the interval with 16-bit wrap, halved to microseconds
    assign w_diff = i_time - i_prev;
    assign w_us   = w_diff[TIME_W-1:1];

    // Window checks against the configured limits
    assign w_armed    = (i_pos != '0) && (i_pos <= LAST_POS);
    assign w_in_pulse = (w_us > i_cfg.pulse_min_us) && (w_us < i_cfg.pulse_max_us);
    assign w_in_sync  = (w_us > i_cfg.sync_min_us) && (w_us < i_cfg.sync_max_us);
    assign w_idx      = i_pos - POS_W'(1);

    // Decide the result and the next frame position
    always_comb begin
        o_res      = '0;
        o_pos_next = '0;
        if (w_armed) begin
            if (w_in_pulse) begin
                o_res.status  = ST_CHANNEL;
                o_res.channel = w_idx[CHAN_W-1:0];
                o_res.value   = VALUE_W'({1'b0, w_us}) - VALUE_W'({1'b0, i_cfg.center_us});
                if (i_pos == LAST_POS) begin
                    o_res.frame_done = 1'b1;
                end else begin
                    o_pos_next = i_pos + POS_W'(1);
                end
            end else begin
                o_res.status = ST_LOST;
            end
        end else if (w_in_sync) begin
            o_res.status = ST_SYNC;
            o_pos_next   = POS_W'(1);
        end
    end

endmodule
